@@ rtl/srts_pkg.sv @@
// ----------------------------------------------------------------------------
// srts_pkg
// Types and constants shared by the sorted record table search block.
// ----------------------------------------------------------------------------
package srts_pkg;

  localparam int unsigned MAX_RECORDS = 256;
  localparam int unsigned IDX_W       = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned INFO_W      = 48;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FOUND  = 2'd1,
    ST_MISS   = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_BASE  = 4'd0,
    REG_STRING_BASE = 4'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] platform_id;
    logic [15:0] encoding_id;
    logic [15:0] language_id;
    logic [15:0] name_id;
    logic [15:0] record_length;
    logic [15:0] record_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_length;
    logic [31:0] found_address;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/srts_ram.sv @@
// ----------------------------------------------------------------------------
// srts_ram
// Simple dual port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module srts_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/srts_ctrl.sv @@
// ----------------------------------------------------------------------------
// srts_ctrl
// Command sequencer: record append and clear, binary search probes, config registers
// and the result/output registers.
// ----------------------------------------------------------------------------
module srts_ctrl import srts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output mem_req_t              mem_req_o,
  output logic [KEY_W-1:0]      key_wdata_o,
  output logic [INFO_W-1:0]     info_wdata_o,
  input  logic [KEY_W-1:0]      key_rdata_i,
  input  logic [INFO_W-1:0]     info_rdata_i
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0] mid_q, mid_d;
  logic [KEY_W-1:0] key_q, key_d, in_key;
  out_item_t        res_q, res_d, out_q;
  logic             out_valid_q, out_load;
  logic [31:0]      table_base_q;
  logic [15:0]      string_base_q;
  logic [CNT_W-1:0] nlo, nhi;
  logic [CNT_W:0]   msum;

  assign in_key = {in_item_i.platform_id, in_item_i.encoding_id,
                   in_item_i.language_id, in_item_i.name_id};

  assign in_stall_o   = (state_q != S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign key_wdata_o  = in_key;
  assign info_wdata_o = {in_item_i.record_length,
                         table_base_q + {16'd0, string_base_q}
                         + {16'd0, in_item_i.record_offset}};
  assign out_valid_o  = out_valid_q;
  assign out_item_o   = out_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    key_d     = key_q;
    res_d     = res_q;
    out_load  = 1'b0;
    mem_req_o = '0;
    nlo       = lo_q;
    nhi       = hi_q;
    msum      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d        = '0;
          res_d.status = ST_LOADED;
          state_d      = S_RESULT;
          case (cmd_e'(in_item_i.cmd))
            CMD_LOAD: begin
              if (count_q == CNT_W'(MAX_RECORDS)) begin
                res_d.status = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = count_q[IDX_W-1:0];
                count_d         = count_q + 1'b1;
              end
            end
            CMD_FIND: begin
              key_d = in_key;
              lo_d  = '0;
              hi_d  = count_q;
              if (count_q == '0) begin
                res_d.status = ST_MISS;
              end else begin
                mid_d           = count_q[CNT_W-1:1];
                mem_req_o.raddr = count_q[CNT_W-1:1];
                state_d         = S_SEARCH;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
            end
            default: begin
              res_d.status = ST_MISS;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (key_q == key_rdata_i) begin
          res_d.status        = ST_FOUND;
          res_d.found_length  = info_rdata_i[47:32];
          res_d.found_address = info_rdata_i[31:0];
          state_d             = S_RESULT;
        end else begin
          if (key_q < key_rdata_i) begin
            nhi = {1'b0, mid_q};
          end else begin
            nlo = {1'b0, mid_q} + 1'b1;
          end
          lo_d = nlo;
          hi_d = nhi;
          msum = {1'b0, nlo} + {1'b0, nhi};
          if (nlo < nhi) begin
            mid_d           = msum[IDX_W:1];
            mem_req_o.raddr = msum[IDX_W:1];
          end else begin
            res_d.status = ST_MISS;
            state_d      = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q  <= '0;
      string_base_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TABLE_BASE:  table_base_q  <= cfg_data_i;
        REG_STRING_BASE: string_base_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECORDS))
    else $error("record count above table size");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> lo_q < hi_q && hi_q <= count_q)
    else $error("search window empty or beyond count");

  a_probe_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> {1'b0, mid_q} >= lo_q && {1'b0, mid_q} < hi_q)
    else $error("probe index outside search window");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not advance record count");

endmodule

@@ rtl/sorted_record_table_search.sv @@
// ----------------------------------------------------------------------------
// sorted_record_table_search
// Name record table with append, binary search and clear commands. The user
// must append in ascending composite key order; the block does not enforce it.
// ----------------------------------------------------------------------------
// One item at a time. For load, clear and unused commands, and a find on an
// empty table, the result is registered on acceptance and moves to the output
// register in the result state, after which the next item can be taken. A find
// first passes through the search state, one probe per memory read, at most
// log2(MAX_RECORDS)+1 probes. The pace is set by the registered read of the key
// and info memories. A stalled output holds the block in its result state until
// the output register frees up. A new item is taken while the previous result
// still waits at the output. The memories come up unwritten and need no
// clearing pass; the record count alone marks which entries are valid.
module sorted_record_table_search import srts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  mem_req_t          mem_req;
  logic [KEY_W-1:0]  key_wdata, key_rdata;
  logic [INFO_W-1:0] info_wdata, info_rdata;

  srts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mem_req_o   (mem_req),
    .key_wdata_o (key_wdata),
    .info_wdata_o(info_wdata),
    .key_rdata_i (key_rdata),
    .info_rdata_i(info_rdata)
  );

  srts_ram #(
    .DEPTH(MAX_RECORDS),
    .WIDTH(KEY_W)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(key_wdata),
    .raddr_i(mem_req.raddr),
    .rdata_o(key_rdata)
  );

  srts_ram #(
    .DEPTH(MAX_RECORDS),
    .WIDTH(INFO_W)
  ) u_info_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(info_wdata),
    .raddr_i(mem_req.raddr),
    .rdata_o(info_rdata)
  );

endmodule
